[sv/brf_pkg.sv]
// Shared constants, types and occupancy arithmetic for the byte ring FIFO.
package brf_pkg;

  localparam int DEPTH     = 1024;
  localparam int MAX_RUN   = 64;
  localparam int CNT_W     = 11;
  localparam int DATA_W    = 8;
  localparam int CMD_W     = 3;
  localparam int PTR_W     = $clog2(DEPTH);
  localparam int ARITH_W   = ((PTR_W > CNT_W) ? PTR_W : CNT_W) + 1;
  localparam int RUN_W     = $clog2(MAX_RUN + 1);
  localparam int CAP_RESET = 1024;

  typedef enum logic [CMD_W-1:0] {
    CMD_ENQ     = 3'd0,
    CMD_DEQ     = 3'd1,
    CMD_PEEK    = 3'd2,
    CMD_ADV_FR  = 3'd3,
    CMD_ADV_RR  = 3'd4,
    CMD_CLEAR   = 3'd5,
    CMD_STATUS  = 3'd6
  } cmd_t;

  typedef enum logic [1:0] {
    JOB_NONE,
    JOB_WRITE,
    JOB_READ
  } job_kind_t;

  typedef struct packed {
    job_kind_t         kind;
    logic              rej;
    logic [DATA_W-1:0] data;
    logic [PTR_W-1:0]  addr;
    logic [RUN_W-1:0]  beats;
    logic [CNT_W-1:0]  cap;
    logic [PTR_W-1:0]  front;
    logic [PTR_W-1:0]  rear;
    logic              full;
  } job_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic [CNT_W-1:0] used;
    logic [CNT_W-1:0] free;
    logic [CNT_W-1:0] cw;
    logic [CNT_W-1:0] cr;
  } occ_t;

  function automatic logic [CNT_W-1:0] brf_clamp(logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (32'(v) > DEPTH) begin
      r = CNT_W'(DEPTH);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // The sum stays below twice the capacity, so one subtract completes the wrap.
  function automatic logic [PTR_W-1:0] brf_advance(logic [PTR_W-1:0] p,
                                                  logic [CNT_W-1:0] n,
                                                  logic [CNT_W-1:0] cap);
    logic [ARITH_W-1:0] s;
    logic [ARITH_W-1:0] c;
    s = ARITH_W'(p) + ARITH_W'(n);
    c = ARITH_W'(cap);
    if (c == '0) begin
      s = '0;
    end else if (s >= c) begin
      s = s - c;
    end
    return PTR_W'(s);
  endfunction

  function automatic occ_t brf_occupancy(logic [CNT_W-1:0] cap, logic [PTR_W-1:0] fp,
                                         logic [PTR_W-1:0] rp, logic full);
    logic [ARITH_W-1:0] c;
    logic [ARITH_W-1:0] f;
    logic [ARITH_W-1:0] r;
    logic [ARITH_W-1:0] u;
    logic [ARITH_W-1:0] w;
    logic [ARITH_W-1:0] rd;
    occ_t o;
    c = ARITH_W'(cap);
    f = ARITH_W'(fp);
    r = ARITH_W'(rp);
    if (c == '0) begin
      u = '0;
    end else if (full) begin
      u = c;
    end else if (r >= f) begin
      u = r - f;
    end else begin
      u = c - (f - r);
    end
    if (c == '0 || full) begin
      w = '0;
    end else if (r >= f) begin
      w = c - r;
    end else begin
      w = f - r;
    end
    if (c == '0) begin
      rd = '0;
    end else if (full || f > r) begin
      rd = c - f;
    end else begin
      rd = r - f;
    end
    o.used = CNT_W'(u);
    o.free = CNT_W'(c - u);
    o.cw   = CNT_W'(w);
    o.cr   = CNT_W'(rd);
    return o;
  endfunction

endpackage

[sv/brf_front.sv]
// Command front end: holds the ring pointers, checks each command and queues a job.
module brf_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [brf_pkg::CMD_W-1:0]     cmd,
  input  logic [brf_pkg::DATA_W-1:0]    data_in,
  input  logic [brf_pkg::CNT_W-1:0]     count,
  input  logic                          run_first,
  input  logic                          cfg_we,
  input  logic [brf_pkg::CNT_W-1:0]     cfg_data,
  output brf_pkg::job_t                 job
);

  logic [brf_pkg::CNT_W-1:0] cap;
  logic [brf_pkg::PTR_W-1:0] front_ptr;
  logic [brf_pkg::PTR_W-1:0] rear_ptr;
  logic                      full_flag;
  logic                      run_accepted;
  logic [brf_pkg::RUN_W-1:0] run_left;

  logic [brf_pkg::PTR_W-1:0] front_ptr_next;
  logic [brf_pkg::PTR_W-1:0] rear_ptr_next;
  logic                      full_flag_next;
  logic                      run_accepted_next;
  logic [brf_pkg::RUN_W-1:0] run_left_next;

  brf_pkg::occ_t             occ;
  logic                      cnt_zero;
  logic                      cap_zero;
  logic                      over_run;
  logic                      ra;
  logic [brf_pkg::RUN_W-1:0] rl;

  always_comb begin
    occ      = brf_pkg::brf_occupancy(cap, front_ptr, rear_ptr, full_flag);
    cnt_zero = (count == '0);
    cap_zero = (cap == '0);
    over_run = (32'(count) > brf_pkg::MAX_RUN);

    front_ptr_next    = front_ptr;
    rear_ptr_next     = rear_ptr;
    full_flag_next    = full_flag;
    run_accepted_next = run_accepted;
    run_left_next     = run_left;
    ra                = run_accepted;
    rl                = run_left;

    job.kind  = brf_pkg::JOB_NONE;
    job.rej   = 1'b0;
    job.data  = data_in;
    job.addr  = rear_ptr;
    job.beats = brf_pkg::RUN_W'(1);

    unique case (cmd)
      brf_pkg::CMD_ENQ: begin
        if (run_first) begin
          if (cnt_zero || over_run || cap_zero || count > occ.free) begin
            ra = 1'b0;
            rl = '0;
          end else begin
            ra = 1'b1;
            rl = brf_pkg::RUN_W'(count);
          end
        end
        run_accepted_next = ra;
        run_left_next     = rl;
        if (!ra || rl == '0) begin
          job.rej = 1'b1;
        end else if (cap_zero || occ.free == '0) begin
          // Advance rear has taken the room: the rest of the run is dropped.
          job.rej           = 1'b1;
          run_accepted_next = 1'b0;
          run_left_next     = '0;
        end else begin
          job.kind          = brf_pkg::JOB_WRITE;
          job.addr          = rear_ptr;
          rear_ptr_next     = brf_pkg::brf_advance(rear_ptr, brf_pkg::CNT_W'(1), cap);
          full_flag_next    = (rear_ptr_next == front_ptr);
          run_left_next     = rl - brf_pkg::RUN_W'(1);
          run_accepted_next = (rl != brf_pkg::RUN_W'(1));
        end
      end
      brf_pkg::CMD_DEQ, brf_pkg::CMD_PEEK: begin
        if (cnt_zero || over_run || cap_zero || count > occ.used) begin
          job.rej = 1'b1;
        end else begin
          job.kind  = brf_pkg::JOB_READ;
          job.addr  = front_ptr;
          job.beats = brf_pkg::RUN_W'(count);
          if (cmd == brf_pkg::CMD_DEQ) begin
            front_ptr_next = brf_pkg::brf_advance(front_ptr, count, cap);
            full_flag_next = 1'b0;
          end
        end
      end
      brf_pkg::CMD_ADV_FR: begin
        if (cnt_zero || cap_zero || count > occ.used) begin
          job.rej = 1'b1;
        end else begin
          front_ptr_next = brf_pkg::brf_advance(front_ptr, count, cap);
          full_flag_next = 1'b0;
        end
      end
      brf_pkg::CMD_ADV_RR: begin
        if (cnt_zero || cap_zero || count > occ.free) begin
          job.rej = 1'b1;
        end else begin
          rear_ptr_next  = brf_pkg::brf_advance(rear_ptr, count, cap);
          full_flag_next = (rear_ptr_next == front_ptr);
        end
      end
      brf_pkg::CMD_CLEAR: begin
        front_ptr_next = '0;
        rear_ptr_next  = '0;
        full_flag_next = 1'b0;
      end
      brf_pkg::CMD_STATUS: begin
      end
      default: begin
        job.rej = 1'b1;
      end
    endcase

    // Every result of the item reports the ring as it stands after the item.
    job.cap   = cap;
    job.front = front_ptr_next;
    job.rear  = rear_ptr_next;
    job.full  = full_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap          <= brf_pkg::brf_clamp(brf_pkg::CNT_W'(brf_pkg::CAP_RESET));
      front_ptr    <= '0;
      rear_ptr     <= '0;
      full_flag    <= 1'b0;
      run_accepted <= 1'b0;
      run_left     <= '0;
    end else if (cfg_we) begin
      cap          <= brf_pkg::brf_clamp(cfg_data);
      front_ptr    <= '0;
      rear_ptr     <= '0;
      full_flag    <= 1'b0;
      run_accepted <= 1'b0;
      run_left     <= '0;
    end else if (accept) begin
      front_ptr    <= front_ptr_next;
      rear_ptr     <= rear_ptr_next;
      full_flag    <= full_flag_next;
      run_accepted <= run_accepted_next;
      run_left     <= run_left_next;
    end
  end

endmodule

[sv/brf_queue.sv]
// Two-entry job queue between the command front end and the storage back end.
module brf_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  brf_pkg::job_t      job_in,
  input  logic               pop,
  output brf_pkg::job_t      head,
  output brf_pkg::q_status_t qs
);

  brf_pkg::job_t ent [2];
  logic          wr_sel;
  logic          rd_sel;
  logic [1:0]    fill;

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_sel] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_sel <= 1'b0;
      rd_sel <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_sel <= ~wr_sel;
      end
      if (pop) begin
        rd_sel <= ~rd_sel;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

  assign head     = ent[rd_sel];
  assign qs.valid = (fill != '0);
  assign qs.full  = (fill == 2'd2);

endmodule

[sv/brf_back.sv]
// Storage back end: owns the byte memory, runs queued jobs and registers each result beat.
module brf_back (
  input  logic                          clk,
  input  logic                          rst,
  input  brf_pkg::job_t                 head,
  input  brf_pkg::q_status_t            qs,
  output logic                          pop,
  output logic                          strobe,
  output logic [brf_pkg::DATA_W-1:0]    data_out,
  output logic                          last,
  output logic                          status,
  output brf_pkg::occ_t                 occ_out
);

  logic [brf_pkg::DATA_W-1:0] mem [brf_pkg::DEPTH];

  logic [brf_pkg::RUN_W-1:0]  idx;
  logic [brf_pkg::PTR_W-1:0]  rd_ptr;
  logic [brf_pkg::PTR_W-1:0]  addr_cur;
  logic                       beat_last;
  logic                       is_read;
  logic                       is_write;
  brf_pkg::occ_t              occ;

  logic [brf_pkg::DATA_W-1:0] rd_data;
  logic                       out_read;

  always_comb begin
    is_read   = qs.valid && (head.kind == brf_pkg::JOB_READ);
    is_write  = qs.valid && (head.kind == brf_pkg::JOB_WRITE);
    addr_cur  = (idx == '0) ? head.addr : rd_ptr;
    beat_last = (head.kind != brf_pkg::JOB_READ) ||
                (idx + brf_pkg::RUN_W'(1) == head.beats);
    pop       = qs.valid && beat_last;
    occ       = brf_pkg::brf_occupancy(head.cap, head.front, head.rear, head.full);
  end

  always_ff @(posedge clk) begin
    if (is_write) begin
      mem[head.addr] <= head.data;
    end
    if (is_read) begin
      rd_data <= mem[addr_cur];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      strobe <= 1'b0;
    end else begin
      strobe <= qs.valid;
      if (pop) begin
        idx <= '0;
      end else if (qs.valid) begin
        idx <= idx + brf_pkg::RUN_W'(1);
      end
    end
  end

  // Beat payload: no reset needed, the strobe qualifies it.
  always_ff @(posedge clk) begin
    if (is_read) begin
      rd_ptr <= brf_pkg::brf_advance(addr_cur, brf_pkg::CNT_W'(1), head.cap);
    end
    if (qs.valid) begin
      out_read <= is_read;
      last     <= beat_last;
      status   <= head.rej;
      occ_out  <= occ;
    end
  end

  assign data_out = out_read ? rd_data : '0;

endmodule

[sv/byte_ring_fifo.sv]
// Byte ring FIFO. The first result beat of a command is registered in the job queue, then in
// the back end's output registers; a command queued behind others waits until their beats
// are out. Single-result commands sustain one per cycle while busy is low; an n-byte dequeue
// or peek gives n beats on consecutive cycles, paced by the one port of the byte memory in the
// back end. busy rises while the two-entry job queue is full; results cannot be held off.
// Synchronous reset clears pointers, flags and run state and sets capacity to 1024, not storage.
module byte_ring_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [brf_pkg::CMD_W-1:0]     cmd,
  input  logic [brf_pkg::DATA_W-1:0]    data_in,
  input  logic [brf_pkg::CNT_W-1:0]     count,
  input  logic                          run_first,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [brf_pkg::CNT_W-1:0]     capacity,
  output logic                          strobe,
  output logic [brf_pkg::DATA_W-1:0]    data_out,
  output logic                          last,
  output logic                          status,
  output logic [brf_pkg::CNT_W-1:0]     used_bytes,
  output logic [brf_pkg::CNT_W-1:0]     free_bytes,
  output logic [brf_pkg::CNT_W-1:0]     contig_write,
  output logic [brf_pkg::CNT_W-1:0]     contig_read
);

  logic               accept;
  logic               pop;
  brf_pkg::job_t      job;
  brf_pkg::job_t      head;
  brf_pkg::q_status_t qs;
  brf_pkg::occ_t      occ_out;

  assign busy      = qs.full;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  brf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .cmd       (cmd),
    .data_in   (data_in),
    .count     (count),
    .run_first (run_first),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (capacity),
    .job       (job)
  );

  brf_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (accept),
    .job_in (job),
    .pop    (pop),
    .head   (head),
    .qs     (qs)
  );

  brf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .qs       (qs),
    .pop      (pop),
    .strobe   (strobe),
    .data_out (data_out),
    .last     (last),
    .status   (status),
    .occ_out  (occ_out)
  );

  assign used_bytes   = occ_out.used;
  assign free_bytes   = occ_out.free;
  assign contig_write = occ_out.cw;
  assign contig_read  = occ_out.cr;

  // A rejected command always gives a single beat.
  a_rej_last: assert property (@(posedge clk) disable iff (rst)
    (strobe && status) |-> last)
    else $error("rejected beat without last");

  a_rej_zero: assert property (@(posedge clk) disable iff (rst)
    (strobe && status) |-> (data_out == '0))
    else $error("rejected beat carries data");

  a_occ_sum: assert property (@(posedge clk) disable iff (rst)
    strobe |-> ((32'(used_bytes) + 32'(free_bytes)) <= brf_pkg::DEPTH))
    else $error("used plus free exceeds storage");

  // A beat can only follow a queued job.
  a_beat_src: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(qs.valid))
    else $error("result beat without a queued job");

endmodule

[tb/byte_ring_fifo_check.sv]
// Checker for the byte ring FIFO: predicts every result beat and compares it with the block.
module byte_ring_fifo_check (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic [brf_pkg::CMD_W-1:0]  cmd,
  input  logic [brf_pkg::DATA_W-1:0] data_in,
  input  logic [brf_pkg::CNT_W-1:0]  count,
  input  logic                       run_first,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [brf_pkg::CNT_W-1:0]  capacity,
  input  logic                       strobe,
  input  logic [brf_pkg::DATA_W-1:0] data_out,
  input  logic                       last,
  input  logic                       status,
  input  logic [brf_pkg::CNT_W-1:0]  used_bytes,
  input  logic [brf_pkg::CNT_W-1:0]  free_bytes,
  input  logic [brf_pkg::CNT_W-1:0]  contig_write,
  input  logic [brf_pkg::CNT_W-1:0]  contig_read,
  output int unsigned                fail_count,
  output int unsigned                beats_due,
  output int unsigned                used_view,
  output int unsigned                free_view,
  output int unsigned                safe_view
);
  timeunit 1ns;
  timeprecision 1ps;

  import brf_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              fin;
    logic              rej;
    logic [CNT_W-1:0]  used;
    logic [CNT_W-1:0]  room;
    logic [CNT_W-1:0]  cw;
    logic [CNT_W-1:0]  cr;
  } ring_beat_t;

  logic [DATA_W-1:0] ring_mem [DEPTH];
  bit                ring_written [DEPTH];
  int unsigned       front_q;
  int unsigned       rear_q;
  int unsigned       cap_q;
  int unsigned       run_left_q;
  bit                full_q;
  bit                run_on_q;
  ring_beat_t        ring_beats [$];

  function automatic int unsigned ring_cap();
    return (cap_q > DEPTH) ? DEPTH : cap_q;
  endfunction

  function automatic int unsigned ring_used();
    int unsigned c;
    c = ring_cap();
    if (c == 0) return 0;
    if (full_q) return c;
    if (rear_q >= front_q) return rear_q - front_q;
    return c - (front_q - rear_q);
  endfunction

  function automatic int unsigned ring_cw();
    int unsigned c;
    c = ring_cap();
    if (c == 0 || full_q) return 0;
    if (rear_q >= front_q) return c - rear_q;
    return front_q - rear_q;
  endfunction

  function automatic int unsigned ring_cr();
    int unsigned c;
    c = ring_cap();
    if (c == 0) return 0;
    if (full_q || front_q > rear_q) return c - front_q;
    return rear_q - front_q;
  endfunction

  function automatic int unsigned ptr_step(int unsigned p, int unsigned n);
    int unsigned c;
    c = ring_cap();
    return (c == 0) ? 0 : (p + n) % c;
  endfunction

  // Every beat of an item carries the occupancy after the whole item.
  function automatic void push_beat(logic [DATA_W-1:0] d, logic lst, logic rej);
    ring_beat_t b;
    int unsigned u;
    u = ring_used();
    b.data = d;
    b.fin  = lst;
    b.rej  = rej;
    b.used = CNT_W'(u);
    b.room = CNT_W'(ring_cap() - u);
    b.cw   = CNT_W'(ring_cw());
    b.cr   = CNT_W'(ring_cr());
    ring_beats.push_back(b);
  endfunction

  function automatic void ring_step(logic [CMD_W-1:0] c, logic [DATA_W-1:0] d,
                                    int unsigned n, logic first);
    logic [DATA_W-1:0] got [MAX_RUN];
    int unsigned cap;
    int unsigned used;
    int unsigned room;
    int unsigned p;
    int unsigned i;
    cap  = ring_cap();
    used = ring_used();
    room = cap - used;
    case (c)
      CMD_ENQ: begin
        // A run start decides the whole run; a refused start also ends any open run.
        if (first) begin
          run_on_q   = (n != 0 && n <= MAX_RUN && cap != 0 && n <= room);
          run_left_q = run_on_q ? n : 0;
        end
        if (!run_on_q || run_left_q == 0) begin
          push_beat('0, 1'b1, 1'b1);
        end else if (cap == 0 || room == 0) begin
          // Advance rear took the space, so the rest of the run is dropped.
          run_on_q   = 1'b0;
          run_left_q = 0;
          push_beat('0, 1'b1, 1'b1);
        end else begin
          ring_mem[rear_q]     = d;
          ring_written[rear_q] = 1'b1;
          rear_q               = ptr_step(rear_q, 1);
          full_q               = (rear_q == front_q);
          run_left_q--;
          if (run_left_q == 0) run_on_q = 1'b0;
          push_beat('0, 1'b1, 1'b0);
        end
      end
      CMD_DEQ, CMD_PEEK: begin
        if (n == 0 || n > MAX_RUN || cap == 0 || n > used) begin
          push_beat('0, 1'b1, 1'b1);
        end else begin
          p = front_q;
          for (i = 0; i < n; i++) begin
            got[i] = ring_mem[p];
            p = ptr_step(p, 1);
          end
          if (c == CMD_DEQ) begin
            front_q = p;
            full_q  = 1'b0;
          end
          for (i = 0; i < n; i++) push_beat(got[i], i + 1 == n, 1'b0);
        end
      end
      CMD_ADV_FR: begin
        if (n == 0 || cap == 0 || n > used) begin
          push_beat('0, 1'b1, 1'b1);
        end else begin
          front_q = ptr_step(front_q, n);
          full_q  = 1'b0;
          push_beat('0, 1'b1, 1'b0);
        end
      end
      CMD_ADV_RR: begin
        if (n == 0 || cap == 0 || n > room) begin
          push_beat('0, 1'b1, 1'b1);
        end else begin
          rear_q = ptr_step(rear_q, n);
          full_q = (rear_q == front_q);
          push_beat('0, 1'b1, 1'b0);
        end
      end
      CMD_CLEAR: begin
        front_q = 0;
        rear_q  = 0;
        full_q  = 1'b0;
        push_beat('0, 1'b1, 1'b0);
      end
      CMD_STATUS: begin
        push_beat('0, 1'b1, 1'b0);
      end
      default: begin
        push_beat('0, 1'b1, 1'b1);
      end
    endcase
  endfunction

  function automatic void note_mismatch(string field, logic [CNT_W-1:0] want,
                                        logic [CNT_W-1:0] got);
    fail_count++;
    $error("%s: expected %0d, got %0d", field, want, got);
  endfunction

  always @(posedge clk) begin : watch_beats
    ring_beat_t want;
    int unsigned p;
    int unsigned k;
    if (rst) begin
      front_q    = 0;
      rear_q     = 0;
      cap_q      = CAP_RESET;
      full_q     = 1'b0;
      run_on_q   = 1'b0;
      run_left_q = 0;
      fail_count = 0;
      ring_beats.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap_q      = 32'(capacity);
        front_q    = 0;
        rear_q     = 0;
        full_q     = 1'b0;
        run_on_q   = 1'b0;
        run_left_q = 0;
      end
      if (start && !busy) ring_step(cmd, data_in, 32'(count), run_first);
      if (strobe) begin
        if (ring_beats.size() == 0) begin
          fail_count++;
          $error("result beat with nothing expected, data_out %0d", data_out);
        end else begin
          want = ring_beats.pop_front();
          if (data_out !== want.data)
            note_mismatch("data_out", CNT_W'(want.data), CNT_W'(data_out));
          if (last !== want.fin) note_mismatch("last", CNT_W'(want.fin), CNT_W'(last));
          if (status !== want.rej)
            note_mismatch("status", CNT_W'(want.rej), CNT_W'(status));
          if (used_bytes !== want.used) note_mismatch("used_bytes", want.used, used_bytes);
          if (free_bytes !== want.room) note_mismatch("free_bytes", want.room, free_bytes);
          if (contig_write !== want.cw) note_mismatch("contig_write", want.cw, contig_write);
          if (contig_read !== want.cr) note_mismatch("contig_read", want.cr, contig_read);
        end
      end
    end
    // Bytes readable from the front, up to MAX_RUN, that have all been written at some point.
    used_view = ring_used();
    free_view = ring_cap() - used_view;
    k = 0;
    p = front_q;
    while (k < used_view && k < MAX_RUN && ring_written[p]) begin
      k++;
      p = ptr_step(p, 1);
    end
    safe_view = k;
    beats_due = ring_beats.size();
  end

endmodule

[tb/byte_ring_fifo_tb.sv]
// Testbench top for the byte ring FIFO: clock, reset, command stimulus and the verdict.
module byte_ring_fifo_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import brf_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED  = 3'd7;
  localparam int unsigned      CYCLE_LIMIT = 400000;

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [CMD_W-1:0]  cmd;
  logic [DATA_W-1:0] data_in;
  logic [CNT_W-1:0]  count;
  logic              run_first;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CNT_W-1:0]  capacity;
  logic              strobe;
  logic [DATA_W-1:0] data_out;
  logic              last;
  logic              status;
  logic [CNT_W-1:0]  used_bytes;
  logic [CNT_W-1:0]  free_bytes;
  logic [CNT_W-1:0]  contig_write;
  logic [CNT_W-1:0]  contig_read;

  int unsigned fail_count;
  int unsigned beats_due;
  int unsigned used_view;
  int unsigned free_view;
  int unsigned safe_view;
  int unsigned idle_pct;
  int unsigned burst_left;
  int unsigned run_todo;
  int unsigned cycle_count;

  byte_ring_fifo i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .data_in      (data_in),
    .count        (count),
    .run_first    (run_first),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .capacity     (capacity),
    .strobe       (strobe),
    .data_out     (data_out),
    .last         (last),
    .status       (status),
    .used_bytes   (used_bytes),
    .free_bytes   (free_bytes),
    .contig_write (contig_write),
    .contig_read  (contig_read)
  );

  byte_ring_fifo_check i_ring_check (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .data_in      (data_in),
    .count        (count),
    .run_first    (run_first),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .capacity     (capacity),
    .strobe       (strobe),
    .data_out     (data_out),
    .last         (last),
    .status       (status),
    .used_bytes   (used_bytes),
    .free_bytes   (free_bytes),
    .contig_write (contig_write),
    .contig_read  (contig_read),
    .fail_count   (fail_count),
    .beats_due    (beats_due),
    .used_view    (used_view),
    .free_view    (free_view),
    .safe_view    (safe_view)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after the command is accepted.
  task automatic send_item(logic [CMD_W-1:0] c, logic [DATA_W-1:0] d,
                           logic [CNT_W-1:0] n, logic f);
    if (burst_left > 0) begin
      burst_left--;
    end else if ($urandom_range(0, 29) == 0) begin
      burst_left = 12;
    end else if ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start     = 1'b1;
    cmd       = c;
    data_in   = d;
    count     = n;
    run_first = f;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Capacity is only written once every expected beat is back.
  task automatic set_capacity(logic [CNT_W-1:0] v);
    start = 1'b0;
    while (beats_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_valid = 1'b1;
    capacity  = v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
    run_todo  = 0;
  endtask

  task automatic random_item();
    int unsigned pick;
    int unsigned n;
    int unsigned u;
    int unsigned fr;
    int unsigned sr;
    u  = used_view;
    fr = free_view;
    sr = safe_view;
    if (run_todo > 0 && $urandom_range(0, 9) != 0) begin
      run_todo--;
      send_item(CMD_ENQ, 8'($urandom), 11'($urandom), 1'b0);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        case ($urandom_range(0, 5))
          0: n = MAX_RUN;
          1: n = 1;
          2: n = $urandom_range(0, 2047);
          default: n = $urandom_range(1, MAX_RUN);
        endcase
        if (fr > 0 && n > fr && n <= MAX_RUN && $urandom_range(0, 3) != 0) n = fr;
        run_todo = (n >= 1 && n <= MAX_RUN && n <= fr) ? n - 1 : 0;
        send_item(CMD_ENQ, 8'($urandom), 11'(n), 1'b1);
      end else if (pick < 70) begin
        // Reads stay within bytes that were written; the rest are refused counts.
        if (sr > 0 && $urandom_range(0, 5) != 0) begin
          n = ($urandom_range(0, 2) == 0) ? sr : $urandom_range(1, sr);
        end else begin
          case ($urandom_range(0, 2))
            0: n = 0;
            1: n = u + 1;
            default: n = $urandom_range(MAX_RUN + 1, 2047);
          endcase
        end
        send_item((pick < 55) ? CMD_DEQ : CMD_PEEK, 8'($urandom), 11'(n), 1'($urandom));
      end else if (pick < 78) begin
        if (u > 0 && $urandom_range(0, 4) != 0) n = $urandom_range(1, u);
        else n = $urandom_range(0, 2047);
        send_item(CMD_ADV_FR, 8'($urandom), 11'(n), 1'($urandom));
      end else if (pick < 85) begin
        if (fr > 0 && $urandom_range(0, 4) != 0) begin
          n = ($urandom_range(0, 3) == 0) ? fr : $urandom_range(1, (fr < 8) ? fr : 8);
        end else begin
          n = $urandom_range(0, 2047);
        end
        send_item(CMD_ADV_RR, 8'($urandom), 11'(n), 1'($urandom));
      end else if (pick < 90) begin
        send_item(CMD_CLEAR, 8'($urandom), 11'($urandom), 1'($urandom));
      end else if (pick < 95) begin
        send_item(CMD_STATUS, 8'($urandom), 11'($urandom), 1'($urandom));
      end else if ($urandom_range(0, 1) == 0) begin
        send_item(CMD_UNUSED, 8'($urandom), 11'($urandom), 1'($urandom));
      end else begin
        send_item(CMD_ENQ, 8'($urandom), 11'($urandom), 1'b0);
      end
    end
  endtask

  task automatic run_phase(logic [CNT_W-1:0] cap, int unsigned items, int unsigned pct);
    set_capacity(cap);
    idle_pct   = pct;
    burst_left = 0;
    repeat (items) random_item();
  endtask

  initial begin
    rst        = 1'b1;
    start      = 1'b0;
    cmd        = CMD_STATUS;
    data_in    = '0;
    count      = '0;
    run_first  = 1'b0;
    cfg_valid  = 1'b0;
    capacity   = CNT_W'(CAP_RESET);
    idle_pct   = 0;
    burst_left = 0;
    run_todo   = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed part at the reset capacity, with the ring starting empty.
    send_item(CMD_DEQ, 8'($urandom), 11'd1, 1'b0);
    send_item(CMD_PEEK, 8'($urandom), 11'd0, 1'b1);
    send_item(CMD_ENQ, 8'h5A, 11'($urandom), 1'b0);
    send_item(CMD_ENQ, 8'h00, 11'd0, 1'b1);
    send_item(CMD_ENQ, 8'hFF, 11'd2047, 1'b1);
    send_item(CMD_ENQ, 8'h00, 11'd3, 1'b1);
    send_item(CMD_ENQ, 8'hFF, 11'd0, 1'b0);
    send_item(CMD_ENQ, 8'hA5, 11'd2047, 1'b0);
    send_item(CMD_ENQ, 8'h3C, 11'd1, 1'b0);
    send_item(CMD_PEEK, 8'($urandom), 11'd3, 1'b0);
    send_item(CMD_DEQ, 8'($urandom), 11'd2, 1'b1);
    send_item(CMD_ADV_FR, 8'($urandom), 11'd0, 1'b0);
    send_item(CMD_ADV_FR, 8'($urandom), 11'd1, 1'b0);
    // Advancing by zero on an empty ring must not mark it full.
    send_item(CMD_ADV_RR, 8'($urandom), 11'd0, 1'b0);
    send_item(CMD_ADV_RR, 8'($urandom), 11'd1024, 1'b0);
    send_item(CMD_STATUS, 8'($urandom), 11'($urandom), 1'b1);
    send_item(CMD_ENQ, 8'h01, 11'd1, 1'b1);
    send_item(CMD_CLEAR, 8'($urandom), 11'($urandom), 1'b0);
    // A refused run start ends the open run.
    send_item(CMD_ENQ, 8'h12, 11'd3, 1'b1);
    send_item(CMD_ENQ, 8'h13, 11'd0, 1'b1);
    send_item(CMD_ENQ, 8'h14, 11'd5, 1'b0);
    // Clear leaves an open run going.
    send_item(CMD_ENQ, 8'h34, 11'd2, 1'b1);
    send_item(CMD_CLEAR, 8'($urandom), 11'($urandom), 1'b1);
    send_item(CMD_ENQ, 8'h56, 11'd9, 1'b0);
    // Advance rear fills the ring under an open run, which then loses its next byte.
    send_item(CMD_ENQ, 8'h78, 11'd2, 1'b1);
    send_item(CMD_ADV_RR, 8'($urandom), 11'd1022, 1'b0);
    send_item(CMD_ENQ, 8'h9A, 11'd0, 1'b0);
    send_item(CMD_UNUSED, 8'hFF, 11'd2047, 1'b1);

    run_phase(11'd0, 8, 0);
    run_phase(11'd2047, 50, 0);
    run_phase(11'd1, 25, 73);
    run_phase(11'd2, 25, 28);
    run_phase(11'd37, 35, 73);
    run_phase(11'd64, 50, 0);
    run_phase(11'd5, 20, 28);
    run_phase(11'd1024, 35, 73);

    start = 1'b0;
    while (beats_due != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[byte_ring_fifo.f]
sv/brf_pkg.sv
sv/brf_front.sv
sv/brf_queue.sv
sv/brf_back.sv
sv/byte_ring_fifo.sv
tb/byte_ring_fifo_check.sv
tb/byte_ring_fifo_tb.sv
